// File: rtl/rlfs_pkg.sv
package rlfs_pkg;

  localparam int ColorW   = 8;
  localparam int NumLanes = 3;
  localparam int DivSteps = ColorW;
  localparam int DivCntW  = $clog2(DivSteps);

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Per-lane command from the sequencer
  typedef struct packed {
    logic set_tgt;    // load target and start a new division
    logic div_step;   // one restoring-division iteration
    logic div_last;   // final iteration: latch the quotient as step
    logic tick_move;  // move one step toward the target
    logic snap;       // copy the target into the current color
  } lane_cmd_t;

endpackage

// File: rtl/rlfs_lane.sv
module rlfs_lane (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rlfs_pkg::lane_cmd_t           cmd,
  input  logic [rlfs_pkg::ColorW-1:0]   new_tgt,
  input  logic [rlfs_pkg::ColorW-1:0]   speed,
  output logic [rlfs_pkg::ColorW-1:0]   cur,
  output logic [rlfs_pkg::ColorW-1:0]   tgt
);
  import rlfs_pkg::*;

  logic [ColorW-1:0] cur_r, cur_nxt;
  logic [ColorW-1:0] tgt_r, tgt_nxt;
  logic [ColorW-1:0] step_r, step_nxt;
  logic [ColorW-1:0] quo_r, quo_nxt;
  logic [ColorW-1:0] rem_r, rem_nxt;

  logic [ColorW:0]   sum;
  logic [ColorW-1:0] gap;
  logic [ColorW-1:0] moved;
  logic [ColorW:0]   rem_sh;
  logic              q_bit;
  logic [ColorW-1:0] abs_diff;

  // Move one step toward the target, clamped at the target
  always_comb begin
    sum = {1'b0, cur_r} + {1'b0, step_r};
    gap = cur_r - tgt_r;
    if (tgt_r > cur_r) begin
      moved = (sum > {1'b0, tgt_r}) ? tgt_r : sum[ColorW-1:0];
    end else if (tgt_r < cur_r) begin
      moved = (step_r >= gap) ? tgt_r : cur_r - step_r;
    end else begin
      moved = cur_r;
    end
  end

  // Restoring division: one quotient bit per iteration
  always_comb begin
    rem_sh   = {rem_r, quo_r[ColorW-1]};
    q_bit    = (rem_sh >= {1'b0, speed});
    abs_diff = (new_tgt > cur_r) ? new_tgt - cur_r : cur_r - new_tgt;
  end

  always_comb begin
    cur_nxt  = cur_r;
    tgt_nxt  = tgt_r;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    if (cmd.set_tgt) begin
      tgt_nxt = new_tgt;
      quo_nxt = abs_diff;
      rem_nxt = '0;
    end
    if (cmd.div_step) begin
      rem_nxt = q_bit ? ColorW'(rem_sh - {1'b0, speed}) : rem_sh[ColorW-1:0];
      quo_nxt = {quo_r[ColorW-2:0], q_bit};
      if (cmd.div_last) begin
        step_nxt = {quo_r[ColorW-2:0], q_bit};
      end
    end
    if (cmd.tick_move) begin
      cur_nxt = moved;
    end
    if (cmd.snap) begin
      cur_nxt = tgt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r  <= '0;
      tgt_r  <= '0;
      step_r <= '0;
    end else begin
      cur_r  <= cur_nxt;
      tgt_r  <= tgt_nxt;
      step_r <= step_nxt;
    end
  end

  // Division scratch holds no state across items
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign cur = cur_r;
  assign tgt = tgt_r;

endmodule

// File: rtl/rgb_linear_fade_stepper_top.sv
// A tick item, or a set item that loads no new steps, moves from acceptance to
// ST_DONE, where its result is registered; a set item that loads new steps first
// runs 8 per-lane restoring divider iterations in ST_DIV, then the result load.
// One item at a time: the input stays stalled until the result is registered
// into a free output.
// Reset: synchronous, active low; clears pixel state and out_valid, fade_enable 1.
module rgb_linear_fade_stepper_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_operation,
  input  logic [rlfs_pkg::ColorW-1:0] in_target_red,
  input  logic [rlfs_pkg::ColorW-1:0] in_target_green,
  input  logic [rlfs_pkg::ColorW-1:0] in_target_blue,
  input  logic [rlfs_pkg::ColorW-1:0] in_speed,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [rlfs_pkg::ColorW-1:0] out_red,
  output logic [rlfs_pkg::ColorW-1:0] out_green,
  output logic [rlfs_pkg::ColorW-1:0] out_blue,
  output logic [rlfs_pkg::ColorW-1:0] out_steps_left
);
  import rlfs_pkg::*;

  localparam logic [DivCntW-1:0] DIV_LAST = DivCntW'(DivSteps - 1);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_t;

  state_t             state_r, state_nxt;
  logic [DivCntW-1:0] div_cnt_r, div_cnt_nxt;
  logic [ColorW-1:0]  cnt_r, cnt_nxt;
  logic [ColorW-1:0]  spd_r, spd_nxt;
  logic               fade_r, fade_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ColorW-1:0]  out_red_r, out_red_nxt;
  logic [ColorW-1:0]  out_green_r, out_green_nxt;
  logic [ColorW-1:0]  out_blue_r, out_blue_nxt;
  logic [ColorW-1:0]  out_left_r, out_left_nxt;

  lane_cmd_t          cmd;
  logic               accept;
  logic               differs;
  logic [ColorW-1:0]  new_tgt [NumLanes];
  logic [ColorW-1:0]  cur     [NumLanes];
  logic [ColorW-1:0]  tgt     [NumLanes];

  assign new_tgt[0] = in_target_red;
  assign new_tgt[1] = in_target_green;
  assign new_tgt[2] = in_target_blue;

  // One lane per color channel
  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    rlfs_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .cmd     (cmd),
      .new_tgt (new_tgt[g]),
      .speed   (spd_r),
      .cur     (cur[g]),
      .tgt     (tgt[g])
    );
  end

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign differs  = (new_tgt[0] != tgt[0]) || (new_tgt[1] != tgt[1]) ||
                    (new_tgt[2] != tgt[2]);

  // Sequence the lanes and merge their colors into the output register
  always_comb begin
    state_nxt     = state_r;
    div_cnt_nxt   = div_cnt_r;
    cnt_nxt       = cnt_r;
    spd_nxt       = spd_r;
    fade_nxt      = cfg_wr_en ? cfg_wr_data : fade_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_red_nxt   = out_red_r;
    out_green_nxt = out_green_r;
    out_blue_nxt  = out_blue_r;
    out_left_nxt  = out_left_r;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_DONE;
          if (in_operation == OP_SET) begin
            if (differs) begin
              cmd.set_tgt = 1'b1;
              cnt_nxt     = in_speed;
              spd_nxt     = in_speed;
              if (fade_r && (in_speed != '0)) begin
                state_nxt   = ST_DIV;
                div_cnt_nxt = '0;
              end
            end
          end else if (cnt_r != '0) begin
            cmd.tick_move = fade_r;
            cnt_nxt       = cnt_r - 1'b1;
          end else begin
            cmd.snap = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.div_last = (div_cnt_r == DIV_LAST);
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_red_nxt   = cur[0];
          out_green_nxt = cur[1];
          out_blue_nxt  = cur[2];
          out_left_nxt  = cnt_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      div_cnt_r   <= '0;
      cnt_r       <= '0;
      fade_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      div_cnt_r   <= div_cnt_nxt;
      cnt_r       <= cnt_nxt;
      fade_r      <= fade_nxt;
      out_valid_r <= out_valid_nxt;
    end
    spd_r       <= spd_nxt;
    out_red_r   <= out_red_nxt;
    out_green_r <= out_green_nxt;
    out_blue_r  <= out_blue_nxt;
    out_left_r  <= out_left_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_red_r;
  assign out_green      = out_green_r;
  assign out_blue       = out_blue_r;
  assign out_steps_left = out_left_r;

`ifndef NO_ASSERTIONS
  // Divider busy keeps the input channel closed
  a_div_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> in_stall)
    else $error("input open during division");

  // Division ends after the last iteration
  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && div_cnt_r == DIV_LAST) |=> (state_r == ST_DONE))
    else $error("division did not finish");

  // A tick on a running countdown decrements it by one
  a_tick_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == OP_TICK && cnt_r != '0)
      |=> (cnt_r == ColorW'($past(cnt_r) - 1'b1)))
    else $error("countdown not decremented");
`endif

endmodule
